[rtl/core/kdbs_pkg.sv]
`default_nettype none
package kdbs_pkg;

  localparam int unsigned KEY_W = 56;

  // Register map (word index)
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [3:0] CAPACITY_RESET = 4'd5;

  // Item kinds
  localparam logic KIND_PUSH   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_PUSHED    = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_REMOVED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture item and slot match vector
    logic exec;  // update stack, issue result
  } kdbs_cmd_t;

endpackage
`default_nettype wire

[rtl/core/kdbs_ctrl.sv]
`default_nettype none
module kdbs_ctrl
  import kdbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output kdbs_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.exec  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r == S_EXEC);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/kdbs_dp.sv]
`default_nettype none
module kdbs_dp
  import kdbs_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kdbs_cmd_t        cmd,
  input  wire logic [3:0]       cap_limit,
  input  wire logic             in_kind,
  input  wire logic [KEY_W-1:0] in_plate,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [2:0]            out_entries_above,
  output logic [3:0]            out_occupancy
);

  localparam int unsigned IW = $clog2(MAX_DEPTH);
  localparam int unsigned FW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned WW = (FW > 4) ? FW : 4;
  localparam logic [WW-1:0] DEPTH_W = WW'(MAX_DEPTH);

  logic [KEY_W-1:0]     slot_r [MAX_DEPTH];
  logic [FW-1:0]        fill_r, fill_nxt;
  logic                 kind_r;
  logic [KEY_W-1:0]     key_r;
  logic [MAX_DEPTH-1:0] match_r, match_nxt;

  logic                 valid_r;
  logic [1:0]           status_r, status_nxt;
  logic [2:0]           above_r;
  logic [3:0]           occ_r;

  logic [WW-1:0]        fill_w, lim_w, above_w, occ_w;
  logic                 push_ok, found;
  logic [IW-1:0]        pos;
  logic [MAX_DEPTH-1:0] shift_en;

  // Parallel key compare against live entries only
  always_comb begin
    for (int j = 0; j < MAX_DEPTH; j++) begin
      match_nxt[j] = (slot_r[j] == in_plate) && (FW'(j) < fill_r);
    end
  end

  // Highest matching slot wins: the scan runs upward and keeps the last match
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (match_r[i]) pos = IW'(i);
    end
  end

  assign found  = |match_r;
  assign fill_w = WW'(fill_r);
  // Limit above the depth acts as the depth
  assign lim_w  = (WW'(cap_limit) > DEPTH_W) ? DEPTH_W : WW'(cap_limit);
  assign push_ok = (fill_w < lim_w) && (fill_w < DEPTH_W);

  always_comb begin
    for (int j = 0; j < MAX_DEPTH; j++) begin
      shift_en[j] = found && (IW'(j) >= pos) && (j + 1 < MAX_DEPTH);
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    status_nxt = ST_NOT_FOUND;
    above_w    = '0;
    if (kind_r == KIND_PUSH) begin
      if (push_ok) begin
        fill_nxt   = fill_r + FW'(1);
        status_nxt = ST_PUSHED;
      end else begin
        status_nxt = ST_FULL;
      end
    end else if (found) begin
      fill_nxt   = fill_r - FW'(1);
      status_nxt = ST_REMOVED;
      above_w    = fill_w - WW'(1) - WW'(pos);
    end
  end

  assign occ_w = WW'(fill_nxt);

  // Key slots: no reset, entries at or above fill are never matched
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int j = 0; j < MAX_DEPTH; j++) begin
        if (kind_r == KIND_PUSH) begin
          if (push_ok && (fill_r == FW'(j))) slot_r[j] <= key_r;
        end else if (shift_en[j]) begin
          slot_r[j] <= slot_r[(j + 1) % MAX_DEPTH];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      key_r   <= in_plate;
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      above_r  <= above_w[2:0];
      occ_r    <= occ_w[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
      if (cmd.exec) fill_r <= fill_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_status        = status_r;
  assign out_entries_above = above_r;
  assign out_occupancy     = occ_r;

endmodule
`default_nettype wire

[rtl/core/keyed_delete_bounded_stack.sv]
`default_nettype none
// Bounded stack of 56-bit keys with removal by key. An item is taken when
// start is high and busy is low; busy then stays high for one cycle and the
// result appears on the out_ ports for exactly one cycle, flagged by
// out_valid, in the cycle after that. The key is first compared against
// every held slot at once and the match vector registered; then the
// top-most match is encoded and the entries above it shift down (or a
// push is written). A new item may be issued while the previous result
// is on the out_ ports. The receiver cannot stall: sample out_ ports
// whenever out_valid is high. The capacity limit (reset 5) sits at word
// address 0 of the APB port; write it only while the block is idle.
module keyed_delete_bounded_stack
  import kdbs_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // item channel
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             in_kind,
  input  wire logic [KEY_W-1:0] in_plate,
  // result channel
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [2:0]            out_entries_above,
  output logic [3:0]            out_occupancy,
  // configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  kdbs_cmd_t  cmd;
  logic [3:0] cap_limit_r;
  logic       cfg_wr;

  // APB: zero wait states; word index is paddr[2], byte lanes ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_limit_r <= CAPACITY_RESET;
    end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
      cap_limit_r <= pwdata[3:0];
    end
  end

  // Unmapped word reads back as zero
  assign prdata = (paddr[2] == REG_CAPACITY) ? {28'd0, cap_limit_r} : 32'd0;

  kdbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  kdbs_dp #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cap_limit         (cap_limit_r),
    .in_kind           (in_kind),
    .in_plate          (in_plate),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_entries_above (out_entries_above),
    .out_occupancy     (out_occupancy)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy for the following cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // Every busy cycle is followed by a result
  a_busy_result : assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid)
    else $error("result missing after busy cycle");

  // Position count is only reported for a removal
  a_above_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_REMOVED)) |-> (out_entries_above == 3'd0))
    else $error("entries_above set without removal");

  // Results come only out of a busy cycle
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without item");
`endif

endmodule
`default_nettype wire
